// ===== src/timer_paced_waveform_player_core_assert.svh =====
// Assertion macros used by the waveform player port checker
`ifndef TIMER_PACED_WAVEFORM_PLAYER_CORE_ASSERT_SVH
`define TIMER_PACED_WAVEFORM_PLAYER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TPWP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpwp check failed");

// Next-cycle implication, disabled during reset
`define TPWP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpwp check failed");

`endif

// ===== src/tpwp_pkg.sv =====
// Types, constants and codes for the timer-paced waveform player
package tpwp_pkg;

  // Field widths
  localparam int CLK_W    = 28;
  localparam int RATE_W   = 24;
  localparam int CODE_W   = 12;
  localparam int IDX_W    = 8;
  localparam int OP_W     = 3;
  localparam int PRE_W    = 6;
  localparam int RELOAD_W = 16;

  // Stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  // Defaults and constants
  localparam int BUFFER_DEPTH_DEF = 256;
  localparam int CLOCK_RESET      = 120000000;
  localparam int DEFAULT_RATE     = 256000;
  localparam logic [CODE_W-1:0]   MID_SCALE    = 12'd2048;
  localparam logic [CLK_W-1:0]    PERIOD_MAX   = 28'd65536;
  localparam logic [RELOAD_W-1:0] RESET_RELOAD = RELOAD_W'(CLOCK_RESET / DEFAULT_RATE - 1);

  // Prescaler settings (divide ratio minus one)
  localparam logic [PRE_W-1:0] PRE_X1  = 6'd0;
  localparam logic [PRE_W-1:0] PRE_X8  = 6'd7;
  localparam logic [PRE_W-1:0] PRE_X64 = 6'd63;

  // Divider step counter
  localparam int DIV_CNT_W = $clog2(CLK_W + 1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_WRITE = 3'd1,
    OP_START = 3'd2,
    OP_STOP  = 3'd3,
    OP_RATE  = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [CLK_W-1:0]  dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CLK_W-1:0] quotient;
  } div_resp_t;

endpackage

// ===== src/timer_paced_waveform_player_core.sv =====
// Timer-paced waveform player: sample store, pacing timer and rate setup
//
// Plays a circular store of BUFFER_DEPTH 12-bit samples, one result beat per input beat.
// After reset the store is filled with mid-scale, during which s_tready is low
// (timer_clock_hz writes are still taken). One item is handled at a time: tick, write,
// stop and unused opcodes go through execute and emit; start and change-rate also wait
// on the 28-step shared restoring divider that computes timer_clock_hz / rate_hz.
// The result beat sits in an output register, so the next beat is taken while it waits.
module timer_paced_waveform_player_core import tpwp_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration: timer_clock_hz
  input  logic                   cfg_wr_en,
  input  logic [CLK_W-1:0]       cfg_wr_data,
  // Input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [7:0] sample_index, [19:8] sample_value, [43:20] rate_hz, [47:44] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [2:0] opcode
  input  logic [OP_W-1:0]        s_tuser,
  // Result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [11:0] dac_code, [12] output_on, [13] active, [14] new_sample,
  // [20:15] prescale_setting, [36:21] reload_value, [39:37] zero
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int IW        = $clog2(BUFFER_DEPTH);
  localparam int IDX_EXT_W = (IW > IDX_W) ? IW : IDX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(BUFFER_DEPTH - 1);

  state_t state, state_next;

  // Latched item
  logic [OP_W-1:0]   op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CODE_W-1:0] val_q;
  logic [RATE_W-1:0] rate_q;

  // Block state
  logic [CLK_W-1:0]    timer_clock;
  logic [IW-1:0]       clr_addr;
  logic [IW-1:0]       play_index, play_index_next;
  logic [PRE_W-1:0]    prescale_reg, prescale_reg_next;
  logic [RELOAD_W-1:0] reload_reg, reload_reg_next;
  logic [PRE_W-1:0]    prescale_count, prescale_count_next;
  logic [RELOAD_W-1:0] period_count, period_count_next;
  logic [CODE_W-1:0]   held_code, held_code_next;
  logic                run_flag, run_flag_next;
  logic                fresh, fresh_next;
  logic                m_load;

  // Store ports
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [CODE_W-1:0] ram_wdata;
  logic [CODE_W-1:0] ram_rdata;

  // Divider
  div_req_t  div_req;
  div_resp_t div_resp;

  // Write index range check and address
  logic [IDX_EXT_W-1:0] idx_ext;
  logic                 idx_ok;
  logic [IW-1:0]        idx_addr;

  // Prescaler and reload selection from the quotient
  logic [CLK_W-1:0]    q;
  logic [CLK_W-1:0]    per_sel;
  logic [PRE_W-1:0]    pre_sel;
  logic [RELOAD_W-1:0] reload_sel;

  assign idx_ext  = IDX_EXT_W'(idx_q);
  assign idx_ok   = (IDX_EXT_W + 1)'(idx_q) < (IDX_EXT_W + 1)'(BUFFER_DEPTH);
  assign idx_addr = idx_ext[IW-1:0];

  tpwp_ram #(
    .WIDTH (CODE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (play_index),
    .rdata (ram_rdata)
  );

  tpwp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  // Divider request: zero rate counts as one
  always_comb begin
    div_req.start    = (state == ST_EXEC) && (op_q == OP_START || op_q == OP_RATE);
    div_req.dividend = timer_clock;
    div_req.divisor  = (rate_q == '0) ? RATE_W'(1) : rate_q;
  end

  // Pick prescaler 1, 8 or 64, then clamp period to 1..65536
  always_comb begin
    q = div_resp.quotient;
    if (q <= PERIOD_MAX) begin
      pre_sel = PRE_X1;
      per_sel = q;
    end else if ((q >> 3) <= PERIOD_MAX) begin
      pre_sel = PRE_X8;
      per_sel = q >> 3;
    end else begin
      pre_sel = PRE_X64;
      per_sel = q >> 6;
    end
    if (per_sel == '0) begin
      reload_sel = '0;
    end else if (per_sel > PERIOD_MAX) begin
      reload_sel = '1;
    end else begin
      reload_sel = RELOAD_W'(per_sel - CLK_W'(1));
    end
  end

  // Sequencer: next state, datapath next values and store write
  always_comb begin
    state_next          = state;
    play_index_next     = play_index;
    prescale_reg_next   = prescale_reg;
    reload_reg_next     = reload_reg;
    prescale_count_next = prescale_count;
    period_count_next   = period_count;
    held_code_next      = held_code;
    run_flag_next       = run_flag;
    fresh_next          = fresh;
    ram_we              = 1'b0;
    ram_waddr           = clr_addr;
    ram_wdata           = MID_SCALE;
    s_tready            = 1'b0;
    m_load              = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        fresh_next = 1'b0;
        state_next = ST_EMIT;
        unique case (op_q)
          OP_TICK: begin
            // Prescaler, then period; overflow loads the next sample
            if (run_flag) begin
              if (prescale_count >= prescale_reg) begin
                prescale_count_next = '0;
                if (period_count >= reload_reg) begin
                  period_count_next = '0;
                  held_code_next    = ram_rdata;
                  play_index_next   = (play_index == LAST_IDX) ? '0
                                                               : play_index + IW'(1);
                  fresh_next        = 1'b1;
                end else begin
                  period_count_next = period_count + RELOAD_W'(1);
                end
              end else begin
                prescale_count_next = prescale_count + PRE_W'(1);
              end
            end
          end
          OP_WRITE: begin
            if (idx_ok) begin
              ram_we    = 1'b1;
              ram_waddr = idx_addr;
              ram_wdata = val_q;
            end
          end
          OP_START: begin
            run_flag_next = 1'b0;
            state_next    = ST_DIV;
          end
          OP_STOP: begin
            run_flag_next = 1'b0;
          end
          OP_RATE: begin
            state_next = ST_DIV;
          end
          default: begin
          end
        endcase
      end

      ST_DIV: begin
        // Forced update: new prescaler and reload, counters cleared
        if (div_resp.done) begin
          prescale_reg_next   = pre_sel;
          reload_reg_next     = reload_sel;
          prescale_count_next = '0;
          period_count_next   = '0;
          if (op_q == OP_START) begin
            play_index_next = '0;
            run_flag_next   = 1'b1;
          end
          state_next = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          m_load     = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Player registers
  always_ff @(posedge clk) begin
    if (rst) begin
      play_index     <= '0;
      prescale_reg   <= PRE_X1;
      reload_reg     <= RESET_RELOAD;
      prescale_count <= '0;
      period_count   <= '0;
      held_code      <= '0;
      run_flag       <= 1'b0;
      fresh          <= 1'b0;
      clr_addr       <= '0;
    end else begin
      play_index     <= play_index_next;
      prescale_reg   <= prescale_reg_next;
      reload_reg     <= reload_reg_next;
      prescale_count <= prescale_count_next;
      period_count   <= period_count_next;
      held_code      <= held_code_next;
      run_flag       <= run_flag_next;
      fresh          <= fresh_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + IW'(1);
      end
    end
  end

  // Timer clock register
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_clock <= CLK_W'(CLOCK_RESET);
    end else if (cfg_wr_en) begin
      timer_clock <= cfg_wr_data;
    end
  end

  // Input beat capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q   <= s_tuser;
      idx_q  <= s_tdata[7:0];
      val_q  <= s_tdata[19:8];
      rate_q <= s_tdata[43:20];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (m_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_load) begin
      m_tdata <= {3'b000, reload_reg, prescale_reg, fresh, run_flag, run_flag, held_code};
    end
  end

endmodule

// ===== src/tpwp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
module tpwp_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tpwp_div.sv =====
// Restoring divider, one quotient bit per cycle
module tpwp_div import tpwp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output div_resp_t resp
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CLK_W-1:0]     dvd;
  logic [RATE_W-1:0]    rem;
  logic [RATE_W-1:0]    dsr;

  logic [RATE_W:0]      rem_sh;
  logic                 ge;
  logic [RATE_W:0]      rem_sub;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem, dvd[CLK_W-1]};
    ge      = rem_sh >= {1'b0, dsr};
    rem_sub = rem_sh - {1'b0, dsr};
  end

  // Control: busy for CLK_W steps, then one done cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(CLK_W);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - DIV_CNT_W'(1);
      end
    end
  end

  // Datapath: dividend register fills with quotient bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy && cnt != '0) begin
      dvd <= {dvd[CLK_W-2:0], ge};
      rem <= ge ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
    end
  end

  assign resp.done     = busy && (cnt == '0);
  assign resp.quotient = dvd;

endmodule

// ===== src/tpwp_checker.sv =====
// Port-level checks for the waveform player, bound to the top level
`include "timer_paced_waveform_player_core_assert.svh"

module tpwp_checker import tpwp_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // Pin drive follows playback state
  `TPWP_ASSERT_NOW(a_on_matches_active, clk, rst, m_tvalid, m_tdata[12] == m_tdata[13])

  // A fresh sample only comes while playing
  `TPWP_ASSERT_NOW(a_fresh_needs_active, clk, rst, m_tvalid && m_tdata[14], m_tdata[13])

  // Prescaler is always one of the three settings
  `TPWP_ASSERT_NOW(a_prescale_legal, clk, rst, m_tvalid,
    m_tdata[20:15] == PRE_X1 || m_tdata[20:15] == PRE_X8 || m_tdata[20:15] == PRE_X64)

  // One item at a time: no accept right after an accept
  `TPWP_ASSERT_NEXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready)

  // Stalled result beat holds
  `TPWP_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata))

endmodule

bind timer_paced_waveform_player_core tpwp_checker u_tpwp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== bench/tpwp_player_checker.sv =====
// Checker for the waveform player: tracks the player state and compares every result beat
`timescale 1ns / 1ps

module tpwp_player_checker import tpwp_pkg::*; #(
  parameter int DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CLK_W-1:0]       cfg_wr_data,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  // [7:0] sample_index, [19:8] sample_value, [43:20] rate_hz, [47:44] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [2:0] opcode
  input  logic [OP_W-1:0]        s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // [11:0] dac_code, [12] output_on, [13] active, [14] new_sample,
  // [20:15] prescale_setting, [36:21] reload_value, [39:37] zero
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     errors,
  output int                     pending
);

  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic                drive_on;
    logic                running;
    logic                fresh;
    logic [PRE_W-1:0]    pre;
    logic [RELOAD_W-1:0] reload;
  } dac_beat_t;

  // Mirror of the player state
  logic [CODE_W-1:0]   samples [DEPTH];
  logic [CLK_W-1:0]    timer_hz;
  int                  play_pos;
  logic [PRE_W-1:0]    pre_setting;
  logic [RELOAD_W-1:0] period_reload;
  logic [PRE_W-1:0]    pre_cnt;
  logic [RELOAD_W-1:0] period_cnt;
  logic [CODE_W-1:0]   held;
  logic                playing;

  dac_beat_t due_beats[$];
  int        fail_total = 0;

  task automatic clear_player();
    for (int i = 0; i < DEPTH; i++) samples[i] = MID_SCALE;
    timer_hz      = CLK_W'(CLOCK_RESET);
    play_pos      = 0;
    pre_setting   = PRE_X1;
    period_reload = RESET_RELOAD;
    pre_cnt       = '0;
    period_cnt    = '0;
    held          = '0;
    playing       = 1'b0;
  endtask

  // Prescaler / reload selection; zero rate counts as 1 Hz
  task automatic program_rate(input logic [RATE_W-1:0] rate);
    longint unsigned hz;
    longint unsigned r;
    longint unsigned per;
    logic [PRE_W-1:0] pre;
    hz  = 64'(timer_hz);
    r   = (rate == '0) ? 64'(1) : 64'(rate);
    pre = PRE_X1;
    per = hz / r;
    if (per > PERIOD_MAX) begin
      pre = PRE_X8;
      per = hz / (8 * r);
    end
    if (per > PERIOD_MAX) begin
      pre = PRE_X64;
      per = hz / (64 * r);
    end
    if (per < 1) per = 1;
    if (per > PERIOD_MAX) per = PERIOD_MAX;
    pre_setting   = pre;
    period_reload = RELOAD_W'(per - 1);
    pre_cnt       = '0;
    period_cnt    = '0;
  endtask

  task automatic advance_player(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic [CODE_W-1:0] val, input logic [RATE_W-1:0] rate,
                                output dac_beat_t res);
    logic fresh;
    fresh = 1'b0;
    case (op)
      OP_TICK: begin
        if (playing) begin
          if (pre_cnt >= pre_setting) begin
            pre_cnt = '0;
            if (period_cnt >= period_reload) begin
              period_cnt = '0;
              if (play_pos >= DEPTH) play_pos = 0;
              held     = samples[play_pos];
              play_pos = (play_pos + 1) % DEPTH;
              fresh    = 1'b1;
            end else begin
              period_cnt++;
            end
          end else begin
            pre_cnt++;
          end
        end
      end
      OP_WRITE: begin
        if (idx < DEPTH) samples[idx] = val;
      end
      OP_START: begin
        playing = 1'b0;
        program_rate(rate);
        play_pos = 0;
        playing  = 1'b1;
      end
      OP_STOP: playing = 1'b0;
      OP_RATE: program_rate(rate);
      default: ;
    endcase
    res.code     = held;
    res.drive_on = playing;
    res.running  = playing;
    res.fresh    = fresh;
    res.pre      = pre_setting;
    res.reload   = period_reload;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      fail_total++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Watch both channels and the register port
  always @(posedge clk) begin
    dac_beat_t res;
    dac_beat_t want;
    if (rst) begin
      clear_player();
      due_beats.delete();
    end else begin
      if (cfg_wr_en) timer_hz = cfg_wr_data;
      if (s_tvalid && s_tready) begin
        advance_player(s_tuser, s_tdata[IDX_W-1:0], s_tdata[IDX_W +: CODE_W],
                       s_tdata[IDX_W+CODE_W +: RATE_W], res);
        due_beats.push_back(res);
      end
      if (m_tvalid && m_tready) begin
        if (due_beats.size() == 0) begin
          fail_total++;
          $display("%0t: unexpected result beat, expected none, actual %h", $time, m_tdata);
        end else begin
          want = due_beats.pop_front();
          check_field("dac_code", want.code, m_tdata[CODE_W-1:0]);
          check_field("output_on", want.drive_on, m_tdata[CODE_W]);
          check_field("active", want.running, m_tdata[CODE_W+1]);
          check_field("new_sample", want.fresh, m_tdata[CODE_W+2]);
          check_field("prescale_setting", want.pre, m_tdata[CODE_W+3 +: PRE_W]);
          check_field("reload_value", want.reload, m_tdata[CODE_W+3+PRE_W +: RELOAD_W]);
        end
      end
    end
    errors  <= fail_total;
    pending <= due_beats.size();
  end

endmodule

// ===== bench/tb_timer_paced_waveform_player_core.sv =====
// Testbench top for the waveform player: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_timer_paced_waveform_player_core import tpwp_pkg::*;;

  localparam int HOLD_AT_BEAT  = 300;
  localparam int HOLD_CYCLES   = 80;
  localparam int REGULAR_ITEMS = 35;
  localparam int PLAY_ITEMS    = 300;
  localparam int PLAY_PHASE    = 3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CLK_W-1:0]       cfg_wr_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]        s_tuser = OP_TICK;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  int                     errors;
  int                     pending;

  // Flow-control modes, switched per phase
  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;

  int unsigned phase_clock[5];
  int          rx_gap;
  int          rx_beats = 0;

  timer_paced_waveform_player_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  tpwp_player_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #4000000;
    $display("tb_timer_paced_waveform_player_core: done, errors");
    $finish;
  end

  // Result side: random stalls, one long hold-off to back up the input
  initial begin
    do @(posedge clk); while (rst);
    forever begin
      if (rx_beats == HOLD_AT_BEAT) rx_gap = HOLD_CYCLES;
      else rx_gap = rx_calm ? 0 : $urandom_range(0, 10);
      if (rx_gap != 0) begin
        m_tready <= 1'b0;
        repeat (rx_gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      rx_beats++;
    end
  end

  // One input beat, with a random lead-in gap
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [CODE_W-1:0] val, input logic [RATE_W-1:0] rate);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tuser  <= op;
    s_tdata  <= IN_TDATA_W'({rate, val, idx});
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input logic [RATE_W-1:0] rate);
    send_beat(op, IDX_W'($urandom), CODE_W'($urandom), rate);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_op(OP_TICK, RATE_W'($urandom));
  endtask

  // Hold the input until every outstanding result has been taken
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_clock(input logic [CLK_W-1:0] hz);
    cfg_wr_data <= hz;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Rates spread over all three prescaler ranges, biased toward short periods
  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return RATE_W'($urandom_range(1, 300));
      2:       return RATE_W'($urandom_range(300, 3000));
      3:       return RATE_W'($urandom_range(3000, 1 << 20));
      default: return RATE_W'($urandom_range(1 << 20, (1 << RATE_W) - 1));
    endcase
  endfunction

  // Mixed traffic: mostly ticks, occasional restarts, stops and noise
  task automatic regular_phase(input int n);
    int pick;
    send_op(OP_START, pick_rate());
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 62)      send_op(OP_TICK, RATE_W'($urandom));
      else if (pick < 74) send_op(OP_WRITE, RATE_W'($urandom));
      else if (pick < 80) send_op(OP_START, pick_rate());
      else if (pick < 84) send_op(OP_STOP, RATE_W'($urandom));
      else if (pick < 92) send_op(OP_RATE, pick_rate());
      else send_op(OP_RATE + OP_W'($urandom_range(1, 3)), RATE_W'($urandom));
    end
  endtask

  // Uninterrupted playback long enough for the play index to wrap
  task automatic play_phase(input int n);
    int pick;
    send_op(OP_START, pick_rate());
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 88)      send_op(OP_TICK, RATE_W'($urandom));
      else if (pick < 97) send_op(OP_WRITE, RATE_W'($urandom));
      else send_op(OP_RATE, pick_rate());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: store edges, spare opcodes, prescaler ranges, restart and stop
    send_op(OP_TICK, '1);
    send_beat(OP_WRITE, '0, '1, '0);
    send_beat(OP_WRITE, '1, '0, '1);
    send_beat(OP_WRITE, IDX_W'(1), CODE_W'($urandom), '0);
    for (int op = OP_RATE + 1; op < (1 << OP_W); op++) send_beat(OP_W'(op), '1, '1, '1);
    send_op(OP_RATE, RATE_W'(1000));
    send_op(OP_START, '0);
    send_ticks(1);
    send_op(OP_START, RATE_W'(40000000 / 1000));
    send_op(OP_START, RATE_W'(40000000));
    send_ticks(4);
    send_op(OP_RATE, '1);
    send_ticks(2);
    send_op(OP_STOP, '0);
    send_ticks(1);
    send_op(OP_START, RATE_W'(200));
    send_op(OP_STOP, '1);

    // Random phases, one timer clock setting each
    phase_clock[0] = 1000000;
    phase_clock[1] = 240000000;
    phase_clock[2] = (1 << CLK_W) - 1;
    phase_clock[3] = 0;
    phase_clock[4] = $urandom_range(1000000, 240000000);
    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      write_clock(CLK_W'(phase_clock[ph]));
      tx_calm = (ph == 1);
      rx_calm = (ph == 2) || ($urandom_range(0, 3) == 0);
      if (ph == PLAY_PHASE) play_phase(PLAY_ITEMS);
      else regular_phase(REGULAR_ITEMS);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("tb_timer_paced_waveform_player_core: done, clean");
    else
      $display("tb_timer_paced_waveform_player_core: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/tpwp_pkg.sv
src/tpwp_ram.sv
src/tpwp_div.sv
src/timer_paced_waveform_player_core.sv
src/tpwp_checker.sv
bench/tpwp_player_checker.sv
bench/tb_timer_paced_waveform_player_core.sv
